// ===== sv/yuv422_to_rgb888_converter_macros.svh =====
// Assertion macros for the YUYV to RGB888 converter.
// Included by the top level; no other dependencies.
`ifndef YUV422_TO_RGB888_CONVERTER_MACROS_SVH
`define YUV422_TO_RGB888_CONVERTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define Y2R_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("y2r assertion failed");

// next-cycle implication
`define Y2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("y2r assertion failed");

`else

`define Y2R_ASSERT_IMPL(label, clk, rst, ante, cons)
`define Y2R_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/y2r_pkg.sv =====
// Shared types and constants for the YUYV to RGB888 converter.
// No dependencies.
package y2r_pkg;

   // Q2.14 coefficients
   localparam int unsigned FracBits  = 14;
   localparam int unsigned CoefR     = 23044;  // 1.4065
   localparam int unsigned CoefGu    = 5661;   // 0.3455
   localparam int unsigned CoefGv    = 11746;  // 0.7169
   localparam int unsigned CoefB     = 29147;  // 1.7790
   localparam int unsigned LumaOfs   = 16;
   localparam int unsigned ChromaOfs = 128;

   // worst case sum is about -4.0e6 to +7.6e6, so 25 signed bits leave margin
   localparam int unsigned SumW = 25;

   typedef logic signed [SumW-1:0] sum_type;
   typedef logic signed [8:0]      chroma_type;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } yuyv_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
   } rgb_pair_type;

   // floor(sum / 2^14) clamped to 0..255
   function automatic logic [7:0] clamp_byte(input sum_type sum);
      sum_type shifted;
      shifted = sum >>> FracBits;
      if (sum < 0) begin
         return 8'd0;
      end else if (shifted > sum_type'(255)) begin
         return 8'd255;
      end else begin
         return shifted[7:0];
      end
   endfunction

   // luma minus offset, scaled to Q2.14
   function automatic sum_type luma_term(input logic [7:0] luma);
      return (sum_type'({1'b0, luma}) - sum_type'(LumaOfs)) <<< FracBits;
   endfunction

endpackage

// ===== sv/y2r_ifs.sv =====
// Valid/ready channel interfaces for the YUYV to RGB888 converter.
// Depends on y2r_pkg for the payload types.
interface y2r_yuyv_if import y2r_pkg::*; ();
   logic     valid;
   logic     ready;
   yuyv_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface y2r_rgb_if import y2r_pkg::*; ();
   logic         valid;
   logic         ready;
   rgb_pair_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/yuv422_to_rgb888_converter.sv =====
// Top level: YUYV 4:2:2 group to two RGB888 pixels.
// Depends on y2r_pkg, y2r_ifs.sv and yuv422_to_rgb888_converter_macros.svh.

// Each transaction on req_chan carries one YUYV group (Y0, Cb, Y1, Cr) and
// yields exactly one transaction on rsp_chan with two RGB888 pixels that share
// the chroma. Math is Q2.14: R = Y' + 1.4065 V, G = Y' - 0.3455 U - 0.7169 V,
// B = Y' + 1.7790 U with Y' = Y-16, U = Cb-128, V = Cr-128; each sum is
// floored by 2^14 and clamped to 0..255. The block is a two-register pipe:
// an input register, then four constant multiplies, the adds and the clamps,
// then the result register. An accepted group passes through the input
// register and then the result register, which drives rsp_chan.valid;
// throughput is one group per clock while rsp_chan.ready stays high, set by the
// single pass through the multiply/add stage. Ready propagates back through both
// stages, so a stalled result holds only the stages behind it. No configuration.
`include "yuv422_to_rgb888_converter_macros.svh"

module yuv422_to_rgb888_converter import y2r_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   y2r_yuyv_if.sink        req_chan,
   y2r_rgb_if.source       rsp_chan
);

   // stage 1: captured group
   logic         in_valid_ff, in_valid_in;
   yuyv_type     in_data_ff;
   // stage 2: result register
   logic         out_valid_ff, out_valid_in;
   rgb_pair_type out_data_ff, out_data_in;

   logic out_take;   // result register can load this cycle
   logic in_take;    // input register can load this cycle

   assign out_take = !out_valid_ff || rsp_chan.ready;
   assign in_take  = !in_valid_ff || out_take;

   assign req_chan.ready   = in_take;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // chroma terms shared by both pixels
   chroma_type u_val, v_val;
   sum_type    kr_v, kgu_u, kgv_v, kb_u;
   sum_type    ys_first, ys_second;

   always_comb begin
      u_val = chroma_type'({1'b0, in_data_ff.chroma_blue}) - chroma_type'(ChromaOfs);
      v_val = chroma_type'({1'b0, in_data_ff.chroma_red})  - chroma_type'(ChromaOfs);

      kr_v  = sum_type'(v_val) * sum_type'(CoefR);
      kgu_u = sum_type'(u_val) * sum_type'(CoefGu);
      kgv_v = sum_type'(v_val) * sum_type'(CoefGv);
      kb_u  = sum_type'(u_val) * sum_type'(CoefB);

      ys_first  = luma_term(in_data_ff.luma_first);
      ys_second = luma_term(in_data_ff.luma_second);

      out_data_in.red_first    = clamp_byte(ys_first + kr_v);
      out_data_in.green_first  = clamp_byte(ys_first - kgu_u - kgv_v);
      out_data_in.blue_first   = clamp_byte(ys_first + kb_u);
      out_data_in.red_second   = clamp_byte(ys_second + kr_v);
      out_data_in.green_second = clamp_byte(ys_second - kgu_u - kgv_v);
      out_data_in.blue_second  = clamp_byte(ys_second + kb_u);
   end

   always_comb begin
      in_valid_in  = in_take ? req_chan.valid : in_valid_ff;
      out_valid_in = out_take ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_chan.payload;
      end
      if (out_take) begin
         out_data_ff <= out_data_in;
      end
   end

   // an accepted transaction lands in the input register
   `Y2R_ASSERT_NEXT(a_accept_loads, clock, reset,
      req_chan.valid && req_chan.ready, in_valid_ff)
   // a captured group moves into a free result register
   `Y2R_ASSERT_NEXT(a_stage_advance, clock, reset,
      in_valid_ff && out_take, rsp_chan.valid)
   // both stages full and output stalled: no new transaction taken
   `Y2R_ASSERT_IMPL(a_full_backpressure, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_chan.ready, !req_chan.ready)
   // nothing is presented right after reset
   `Y2R_ASSERT_IMPL(a_reset_empty, clock, 1'b0,
      $past(reset), !rsp_chan.valid)

endmodule

// ===== tb/y2r_pixel_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the YUYV to RGB888 converter: predicts each RGB pair from the
// accepted YUYV groups and compares results. Depends on y2r_pkg and y2r_ifs.sv.
module y2r_pixel_checker import y2r_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   y2r_yuyv_if         yuyv_tap,
   y2r_rgb_if          rgb_tap,
   output int unsigned mismatch_count,
   output int unsigned pairs_pending
);

   // Q2.14 gains
   localparam int RedCrGain   = 23044;
   localparam int GreenCbGain = 5661;
   localparam int GreenCrGain = 11746;
   localparam int BlueCbGain  = 29147;
   localparam int UnityGain   = 16384;

   rgb_pair_type expected_pairs[$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_channel(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // floor by 2^14, then saturate to a byte
   function automatic logic [7:0] saturate_channel(input int acc);
      int scaled;
      scaled = acc >>> 14;
      if (scaled < 0) begin
         return 8'd0;
      end else if (scaled > 255) begin
         return 8'd255;
      end
      return scaled[7:0];
   endfunction

   function automatic logic [23:0] convert_pixel_rgb(input logic [7:0] luma,
                                                     input int cb_ofs,
                                                     input int cr_ofs);
      int luma_scaled;
      luma_scaled = (int'(luma) - 16) * UnityGain;
      return {saturate_channel(luma_scaled + RedCrGain * cr_ofs),
              saturate_channel(luma_scaled - GreenCbGain * cb_ofs - GreenCrGain * cr_ofs),
              saturate_channel(luma_scaled + BlueCbGain * cb_ofs)};
   endfunction

   function automatic rgb_pair_type convert_group(input yuyv_type grp);
      rgb_pair_type pair;
      int           cb_ofs;
      int           cr_ofs;
      cb_ofs = int'(grp.chroma_blue) - 128;
      cr_ofs = int'(grp.chroma_red) - 128;
      {pair.red_first, pair.green_first, pair.blue_first} =
         convert_pixel_rgb(grp.luma_first, cb_ofs, cr_ofs);
      {pair.red_second, pair.green_second, pair.blue_second} =
         convert_pixel_rgb(grp.luma_second, cb_ofs, cr_ofs);
      return pair;
   endfunction

   always @(posedge clock) begin
      rgb_pair_type want;
      if (reset) begin
         expected_pairs.delete();
         pairs_pending  = 0;
         mismatch_count = 0;
      end else begin
         if (yuyv_tap.valid && yuyv_tap.ready) begin
            expected_pairs.push_back(convert_group(yuyv_tap.payload));
         end
         if (rgb_tap.valid && rgb_tap.ready) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               want = expected_pairs.pop_front();
               check_channel("red_first",    rgb_tap.payload.red_first,    want.red_first);
               check_channel("green_first",  rgb_tap.payload.green_first,  want.green_first);
               check_channel("blue_first",   rgb_tap.payload.blue_first,   want.blue_first);
               check_channel("red_second",   rgb_tap.payload.red_second,   want.red_second);
               check_channel("green_second", rgb_tap.payload.green_second, want.green_second);
               check_channel("blue_second",  rgb_tap.payload.blue_second,  want.blue_second);
            end
         end
         pairs_pending = expected_pairs.size();
      end
   end

endmodule

// ===== tb/tb_yuv422_to_rgb888_converter.sv =====
`timescale 1ns / 100ps
// Testbench top for the YUYV to RGB888 converter: drives groups and result
// back-pressure, gives the verdict. Depends on y2r_pkg, y2r_ifs.sv, checker.
module tb_yuv422_to_rgb888_converter import y2r_pkg::*; ();

   localparam int unsigned RandomGroups = 1450;
   localparam int unsigned IdlePercent  = 30;
   localparam int unsigned StallCycles  = 400;     // long result hold-off
   localparam int unsigned DrainCycles  = 8;       // pipe is two deep
   localparam int unsigned CycleLimit   = 200000;  // far above the slowest run

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned pairs_pending;
   int unsigned cycle_count = 0;
   bit          no_idle;    // set during the steady stretch, both sides run flat out
   bit          hold_rsp;   // asks the result side for one long hold-off

   y2r_yuyv_if req_chan ();
   y2r_rgb_if  rsp_chan ();

   // Corner groups, packed as {luma_first, chroma_blue, luma_second, chroma_red}
   yuyv_type corner_groups [16] = '{
      32'h00_00_00_00,   // everything at zero
      32'hff_ff_ff_ff,   // everything at full scale
      32'h10_80_10_80,   // nominal black
      32'heb_80_eb_80,   // nominal white
      32'h00_80_ff_80,   // luma extremes, neutral chroma
      32'h0f_80_11_80,   // luma just below and above the black offset
      32'h80_00_80_00,   // both chroma at minimum
      32'h80_ff_80_ff,   // both chroma at maximum
      32'h80_00_80_ff,   // chroma pulling opposite ways
      32'h80_ff_80_00,
      32'h00_ff_00_00,   // dark luma, strong blue: red driven far negative
      32'hff_00_ff_ff,   // bright luma, strong red: red saturates high
      32'h10_80_10_7f,   // red sum slightly negative, floors below zero
      32'h10_7f_10_80,   // blue sum slightly negative
      32'h55_aa_aa_55,   // alternating bit patterns
      32'haa_55_55_aa
   };

   yuv422_to_rgb888_converter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   y2r_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .yuyv_tap       (req_chan),
      .rgb_tap        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pairs_pending  (pairs_pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one group and hold it until the transaction completes. Random idle
   // cycles go in front of it unless the steady stretch is on. Returns at the
   // falling edge after acceptance so the next group can be driven there.
   task automatic offer_group(input yuyv_type grp);
      while (!no_idle && $urandom_range(99) < IdlePercent) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= grp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: random back-pressure, with one long hold-off on request.
   // The hold-off is counted here so the sender keeps offering meanwhile and
   // the pipe fills and stalls its input.
   initial begin
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (StallCycles) @(negedge clock);
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      yuyv_type    grp;
      int unsigned pick;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      no_idle          = 1'b0;
      hold_rsp         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners
      foreach (corner_groups[i]) begin
         offer_group(corner_groups[i]);
      end

      // sender pause: let every outstanding transaction drain
      req_chan.valid <= 1'b0;
      wait (pairs_pending == 0);
      @(negedge clock);

      // random groups; a steady stretch with no idling, and one long
      // result hold-off while groups keep coming
      for (int unsigned n = 0; n < RandomGroups; n++) begin
         no_idle = (n >= 500 && n < 700);
         if (n == 900) begin
            hold_rsp = 1'b1;
         end
         grp  = yuyv_type'($urandom);
         pick = $urandom_range(99);
         if (pick < 15) begin
            // luma near the ends of the range, where clamping kicks in
            grp.luma_first  = $urandom_range(1) ? 8'($urandom_range(20))
                                                : 8'(235 + $urandom_range(20));
            grp.luma_second = $urandom_range(1) ? 8'($urandom_range(20))
                                                : 8'(235 + $urandom_range(20));
         end else if (pick < 30) begin
            // chroma near its extremes
            grp.chroma_blue = $urandom_range(1) ? 8'($urandom_range(15))
                                                : 8'(240 + $urandom_range(15));
            grp.chroma_red  = $urandom_range(1) ? 8'($urandom_range(15))
                                                : 8'(240 + $urandom_range(15));
         end else if (pick < 45) begin
            // near-gray: small chroma offsets, exercises the floor near zero
            grp.chroma_blue = 8'(118 + $urandom_range(20));
            grp.chroma_red  = 8'(118 + $urandom_range(20));
         end
         offer_group(grp);
      end
      no_idle = 1'b0;
      req_chan.valid <= 1'b0;

      wait (pairs_pending == 0);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && pairs_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
